// File: hw/rtl/pcaprd_pkg.sv
// Package for the capture file record deframer.
// Holds the result kind codes, header constants and the result word type.
// No dependencies.
`default_nettype none

package pcaprd_pkg;

  localparam logic [31:0] MAGIC_MICRO = 32'hA1B2C3D4;
  localparam logic [31:0] MAGIC_NANO  = 32'hA1B23C4D;

  localparam logic [4:0] GLOBAL_HDR_LAST = 5'd23;
  localparam logic [4:0] RECORD_HDR_LAST = 5'd15;
  localparam logic [4:0] MAGIC_LAST      = 5'd3;
  localparam logic [4:0] SECONDS_LAST    = 5'd3;
  localparam logic [4:0] FRACTION_LAST   = 5'd7;
  localparam logic [4:0] CAPLEN_LAST     = 5'd11;

  typedef enum logic [1:0] {
    KIND_HEADER    = 2'd0,
    KIND_PAYLOAD   = 2'd1,
    KIND_BAD_MAGIC = 2'd2
  } kind_t;

  typedef struct packed {
    logic        emit;
    kind_t       kind;
    logic [31:0] ts_seconds;
    logic [31:0] ts_fraction;
    logic        fraction_is_nanoseconds;
    logic [31:0] captured_length;
    logic [7:0]  payload_byte;
    logic        last_in_record;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/pcaprd_if.sv
// Stream interfaces of the capture file record deframer.
// The byte stream in and the result word stream out; no dependencies.
`default_nettype none

interface pcaprd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface pcaprd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] ts_seconds;
  logic [31:0] ts_fraction;
  logic        fraction_is_nanoseconds;
  logic [31:0] captured_length;
  logic [7:0]  payload_byte;
  logic        last_in_record;

  modport source (output valid, output kind, output ts_seconds, output ts_fraction,
                  output fraction_is_nanoseconds, output captured_length,
                  output payload_byte, output last_in_record, input ready);
  modport sink   (input valid, input kind, input ts_seconds, input ts_fraction,
                  input fraction_is_nanoseconds, input captured_length,
                  input payload_byte, input last_in_record, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pcaprd_parser.sv
// Parser state of the capture file record deframer.
// Advances on each accepted byte and computes that byte's result word.
// Depends on pcaprd_pkg.
`default_nettype none

module pcaprd_parser (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic [7:0]          data_byte,
  input  wire logic                final_byte,
  output pcaprd_pkg::result_t      result
);

  typedef enum logic [1:0] {
    PH_GLOBAL  = 2'd0,
    PH_RECORD  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_SKIP    = 2'd3
  } phase_t;

  phase_t      phase, phase_next;
  logic [4:0]  hdr_count, hdr_count_next;
  logic [31:0] field_shift, field_shift_next;
  logic [31:0] seconds_hold, seconds_hold_next;
  logic [31:0] fraction_hold, fraction_hold_next;
  logic [31:0] payload_remaining, payload_remaining_next;
  logic        nano_mode, nano_mode_next;
  logic [31:0] shifted;

  assign shifted = {data_byte, field_shift[31:8]};

  always_comb begin
    phase_next             = phase;
    hdr_count_next         = hdr_count;
    field_shift_next       = field_shift;
    seconds_hold_next      = seconds_hold;
    fraction_hold_next     = fraction_hold;
    payload_remaining_next = payload_remaining;
    nano_mode_next         = nano_mode;
    result                 = '0;
    result.kind            = pcaprd_pkg::KIND_HEADER;

    unique case (phase)
      PH_GLOBAL: begin
        field_shift_next = shifted;
        if (hdr_count == pcaprd_pkg::MAGIC_LAST && shifted != pcaprd_pkg::MAGIC_MICRO &&
            shifted != pcaprd_pkg::MAGIC_NANO) begin
          result.emit = 1'b1;
          result.kind = pcaprd_pkg::KIND_BAD_MAGIC;
          phase_next  = PH_SKIP;
        end else begin
          if (hdr_count == pcaprd_pkg::MAGIC_LAST) begin
            nano_mode_next = (shifted == pcaprd_pkg::MAGIC_NANO);
          end
          if (hdr_count == pcaprd_pkg::GLOBAL_HDR_LAST) begin
            hdr_count_next = '0;
            phase_next     = PH_RECORD;
          end else begin
            hdr_count_next = hdr_count + 5'd1;
          end
        end
      end
      PH_RECORD: begin
        field_shift_next = shifted;
        if (hdr_count == pcaprd_pkg::SECONDS_LAST) begin
          seconds_hold_next = shifted;
        end else if (hdr_count == pcaprd_pkg::FRACTION_LAST) begin
          fraction_hold_next = shifted;
        end else if (hdr_count == pcaprd_pkg::CAPLEN_LAST) begin
          payload_remaining_next = shifted;
        end
        if (hdr_count == pcaprd_pkg::RECORD_HDR_LAST) begin
          hdr_count_next                 = '0;
          result.emit                    = 1'b1;
          result.kind                    = pcaprd_pkg::KIND_HEADER;
          result.ts_seconds              = seconds_hold;
          result.ts_fraction             = fraction_hold;
          result.fraction_is_nanoseconds = nano_mode;
          result.captured_length         = payload_remaining;
          result.last_in_record          = (payload_remaining == '0);
          phase_next = (payload_remaining == '0) ? PH_RECORD : PH_PAYLOAD;
        end else begin
          hdr_count_next = hdr_count + 5'd1;
        end
      end
      PH_PAYLOAD: begin
        result.emit           = 1'b1;
        result.kind           = pcaprd_pkg::KIND_PAYLOAD;
        result.payload_byte   = data_byte;
        result.last_in_record = (payload_remaining <= 32'd1);
        if (payload_remaining != '0) begin
          payload_remaining_next = payload_remaining - 32'd1;
        end
        if (payload_remaining <= 32'd1) begin
          phase_next = PH_RECORD;
        end
      end
      PH_SKIP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && final_byte)) begin
      phase             <= PH_GLOBAL;
      hdr_count         <= '0;
      field_shift       <= '0;
      seconds_hold      <= '0;
      fraction_hold     <= '0;
      payload_remaining <= '0;
      nano_mode         <= 1'b0;
    end else if (accept) begin
      phase             <= phase_next;
      hdr_count         <= hdr_count_next;
      field_shift       <= field_shift_next;
      seconds_hold      <= seconds_hold_next;
      fraction_hold     <= fraction_hold_next;
      payload_remaining <= payload_remaining_next;
      nano_mode         <= nano_mode_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pcaprd_outreg.sv
// Result register of the capture file record deframer.
// Holds one result word and grants the next byte whenever it can be refilled.
// Depends on pcaprd_pkg and pcaprd_if.
`default_nettype none

module pcaprd_outreg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire pcaprd_pkg::result_t result,
  output logic                     take_ready,
  pcaprd_result_if.source          out
);

  logic                valid;
  pcaprd_pkg::result_t held;

  assign take_ready = !valid || out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take_ready) begin
      valid <= accept && result.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take_ready && accept && result.emit) begin
      held <= result;
    end
  end

  assign out.valid                   = valid;
  assign out.kind                    = held.kind;
  assign out.ts_seconds              = held.ts_seconds;
  assign out.ts_fraction             = held.ts_fraction;
  assign out.fraction_is_nanoseconds = held.fraction_is_nanoseconds;
  assign out.captured_length         = held.captured_length;
  assign out.payload_byte            = held.payload_byte;
  assign out.last_in_record          = held.last_in_record;

endmodule

`default_nettype wire

// File: hw/rtl/pcap_record_deframer_unit.sv
// Top level of the capture file record deframer.
// Depends on pcaprd_pkg, pcaprd_if, pcaprd_parser and pcaprd_outreg.
//
// The stream channel carries the capture file one byte per word, with
// final_byte marking its last byte. The result channel carries record
// headers (kind 0), payload bytes (kind 1) and a bad magic report (kind 2).
// Other header bytes and skipped bytes produce no result word.
//
// A byte is accepted every cycle while the result register is empty or
// being drained, so the sustained rate is one byte per cycle. Its result
// appears on the result channel in the cycle after acceptance; the parser
// state update and the result computation fit between the byte handshake
// and the result register.
//
// Reset clears the parser so that a global header is expected and empties
// the result register. The parser restarts the same way after a final
// byte. When the receiver stalls with a result pending, the stream ready
// drops and the pending word holds steady until it is taken.
`default_nettype none

module pcap_record_deframer_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  pcaprd_byte_if.sink       stream,
  pcaprd_result_if.source   result
);

  pcaprd_pkg::result_t parsed;
  logic                take_ready;
  logic                accept;

  assign stream.ready = take_ready;
  assign accept       = stream.valid && take_ready;

  pcaprd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (stream.data_byte),
    .final_byte (stream.final_byte),
    .result     (parsed)
  );

  pcaprd_outreg u_outreg (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .result     (parsed),
    .take_ready (take_ready),
    .out        (result)
  );

endmodule

`default_nettype wire
